>>> sv/hrbs_pkg.sv
// Shared types and constants for the hashed reveal bitmap store.
package hrbs_pkg;

    // Request codes carried on req_type.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_LINE_COUNT   = 1'b0;
    localparam logic CFG_SPRITE_COUNT = 1'b1;

    // FNV-1a 32 constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CLEAR = 7'b0000100,
        ST_LOOK  = 7'b0001000,
        ST_RMW   = 7'b0010000,
        ST_HASH  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

>>> sv/hrbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module hrbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/hashed_reveal_bitmap_store_unit.sv
// Top level of the hashed reveal bitmap store: sequencer, byte store and hash unit.
//
//  Channel   Signals                                             Handshake
//  -------   -------------------------------------------------   ---------------------
//  request   req_type, which_set, item_index, reveal_value       start & !busy
//  result    ok, revealed_out, lines_revealed, sprites_revealed,  done, one cycle
//            state_hash
//  config    cfg_we, cfg_index, cfg_data                         cfg_we, taken at once
//
// After acceptance a rejected request goes straight to done; a read or an unchanged write
// passes through the look-up and read-modify-write states first. A clear zeroes every byte
// of the store, then hashes the used bytes and shows the result (it skips the hash and shows
// a zero hash when a count register is zero); a write that changes a bit also hashes the
// used bytes, where used is the number of bytes in both sets (640 at full set sizes). The
// hash unit folds one byte per cycle from the single read port of the byte store. After
// reset a clearing pass zeroes every byte of the store while busy stays high. The receiver
// cannot stall: each result is shown on the cycle that done is high.
module hashed_reveal_bitmap_store_unit
    import hrbs_pkg::*;
#(
    parameter int MAX_LINES   = 4096,
    parameter int MAX_SPRITES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic        which_set,
    input  logic [11:0] item_index,
    input  logic        reveal_value,
    output logic        done,
    output logic        ok,
    output logic        revealed_out,
    output logic [12:0] lines_revealed,
    output logic [10:0] sprites_revealed,
    output logic [31:0] state_hash,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int STORE_BYTES = (MAX_LINES + 7) / 8 + (MAX_SPRITES + 7) / 8;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);

    state_t          state_reg, state_next;
    logic [12:0]     line_count_reg, sprite_count_reg;
    logic            ready_reg, ready_next;
    logic [12:0]     line_set_count_reg, line_set_count_next;
    logic [10:0]     sprite_set_count_reg, sprite_set_count_next;
    logic [31:0]     store_hash_reg, store_hash_next;
    logic [31:0]     acc_reg, acc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic            ok_reg, ok_next;
    logic            rd_reg, rd_next;
    logic            clear_ok_reg, clear_ok_next;
    logic [1:0]      req_reg, req_next;
    logic            sel_reg, sel_next;
    logic            val_reg, val_next;
    logic [2:0]      bitpos_reg, bitpos_next;
    logic [AW-1:0]   addr_reg, addr_next;

    logic [12:0]     lc;
    logic [10:0]     sc;
    logic [10:0]     lb;
    logic [8:0]      sb;
    logic [11:0]     used;
    logic [CW-1:0]   hash_lim;
    logic [12:0]     bound;
    logic [11:0]     byte_addr;
    logic            in_range;
    logic            hash_issue;
    logic [31:0]     hash_prod;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            cur_bit;
    logic [7:0]      new_byte;

    hrbs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective set sizes and the byte layout they imply.
    always_comb
    begin
        lc = ({19'd0, line_count_reg} > 32'(MAX_LINES)) ? 13'(MAX_LINES) : line_count_reg;
        sc = ({19'd0, sprite_count_reg} > 32'(MAX_SPRITES)) ?
             11'(MAX_SPRITES) : sprite_count_reg[10:0];
        lb = 11'((14'(lc) + 14'd7) >> 3);
        sb = 9'((12'(sc) + 12'd7) >> 3);
        used = 12'(lb) + 12'(sb);
        hash_lim = ({20'd0, used} > 32'(STORE_BYTES)) ? CW'(STORE_BYTES) : CW'(used);
        bound = which_set ? {2'b00, sc} : lc;
        byte_addr = (which_set ? 12'(lb) : 12'd0) + 12'(item_index[11:3]);
        in_range = ({1'b0, item_index} < bound) &&
                   ({20'd0, byte_addr} < 32'(STORE_BYTES));
        hash_issue = cnt_reg < hash_lim;
        hash_prod = 32'((acc_reg ^ {24'd0, ram_rdata}) * FNV_PRIME);
        cur_bit = ram_rdata[bitpos_reg];
        new_byte = ram_rdata;
        new_byte[bitpos_reg] = val_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        line_set_count_next = line_set_count_reg;
        sprite_set_count_next = sprite_set_count_reg;
        store_hash_next = store_hash_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pend_next = 1'b0;
        ok_next = ok_reg;
        rd_next = rd_reg;
        clear_ok_next = clear_ok_reg;
        req_next = req_reg;
        sel_next = sel_reg;
        val_next = val_reg;
        bitpos_next = bitpos_reg;
        addr_next = addr_reg;
        ram_we = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = 8'd0;
        ram_re = 1'b0;
        ram_raddr = cnt_reg[AW-1:0];

        unique case (state_reg) inside
            ST_INIT, ST_CLEAR:
            begin
                // Sweep zeros through every byte of the store.
                ram_we = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(STORE_BYTES - 1))
                begin
                    cnt_next = '0;
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (clear_ok_reg)
                    begin
                        acc_next = FNV_BASIS;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        store_hash_next = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    sel_next = which_set;
                    val_next = reveal_value;
                    bitpos_next = item_index[2:0];
                    addr_next = AW'(byte_addr);
                    ok_next = 1'b0;
                    rd_next = 1'b0;
                    cnt_next = '0;
                    if (req_type == REQ_CLEAR)
                    begin
                        line_set_count_next = '0;
                        sprite_set_count_next = '0;
                        clear_ok_next = (lc != 13'd0) && (sc != 11'd0);
                        ready_next = (lc != 13'd0) && (sc != 11'd0);
                        ok_next = (lc != 13'd0) && (sc != 11'd0);
                        state_next = ST_CLEAR;
                    end
                    else if ((req_type == REQ_READ || req_type == REQ_WRITE) &&
                             ready_reg && in_range)
                    begin
                        ram_re = 1'b1;
                        ram_raddr = AW'(byte_addr);
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOOK:
            begin
                // The addressed byte is already on the read port and is held for the next cycle.
                state_next = ST_RMW;
            end
            ST_RMW:
            begin
                ok_next = 1'b1;
                state_next = ST_DONE;
                if (req_reg == REQ_READ)
                begin
                    rd_next = cur_bit;
                end
                else if (cur_bit != val_reg)
                begin
                    ram_we = 1'b1;
                    ram_waddr = addr_reg;
                    ram_wdata = new_byte;
                    if (sel_reg)
                    begin
                        sprite_set_count_next = sprite_set_count_reg +
                                                (val_reg ? 11'd1 : 11'h7FF);
                    end
                    else
                    begin
                        line_set_count_next = line_set_count_reg +
                                              (val_reg ? 13'd1 : 13'h1FFF);
                    end
                    acc_next = FNV_BASIS;
                    cnt_next = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                // One byte is requested per cycle and folded in the cycle after.
                if (hash_issue)
                begin
                    ram_re = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = hash_prod;
                end
                if (!hash_issue && !pend_reg)
                begin
                    store_hash_next = acc_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            line_count_reg <= 13'd1;
            sprite_count_reg <= 13'd1;
            ready_reg <= 1'b0;
            line_set_count_reg <= '0;
            sprite_set_count_reg <= '0;
            store_hash_reg <= '0;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            ok_reg <= 1'b0;
            rd_reg <= 1'b0;
            clear_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            line_set_count_reg <= line_set_count_next;
            sprite_set_count_reg <= sprite_set_count_next;
            store_hash_reg <= store_hash_next;
            cnt_reg <= cnt_next;
            pend_reg <= pend_next;
            ok_reg <= ok_next;
            rd_reg <= rd_next;
            clear_ok_reg <= clear_ok_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_LINE_COUNT)
                begin
                    line_count_reg <= cfg_data;
                end
                else
                begin
                    sprite_count_reg <= {2'b00, cfg_data[10:0]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        req_reg <= req_next;
        sel_reg <= sel_next;
        val_reg <= val_next;
        bitpos_reg <= bitpos_next;
        addr_reg <= addr_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign ok = ok_reg;
    assign revealed_out = rd_reg;
    assign lines_revealed = line_set_count_reg;
    assign sprites_revealed = sprite_set_count_reg;
    assign state_hash = store_hash_reg;

endmodule

>>> tb/hrbs_checker.sv
`timescale 1ns / 1ps
// Checker for the hashed reveal bitmap store: tracks the store, predicts each result and compares.
module hrbs_checker
    import hrbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic        which_set,
    input  logic [11:0] item_index,
    input  logic        reveal_value,
    input  logic        done,
    input  logic        ok,
    input  logic        revealed_out,
    input  logic [12:0] lines_revealed,
    input  logic [10:0] sprites_revealed,
    input  logic [31:0] state_hash,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output int          mismatch_count,
    output int          pending_count
);

    localparam int LINE_LIMIT   = 4096;
    localparam int SPRITE_LIMIT = 1024;
    localparam int STORE_BYTES  = LINE_LIMIT / 8 + SPRITE_LIMIT / 8;

    typedef struct packed {
        logic        ok;
        logic        bit_rd;
        logic [12:0] lines;
        logic [10:0] sprites;
        logic [31:0] hash;
    } reveal_result_t;

    logic [7:0]     reveal_bytes [STORE_BYTES];
    logic           store_ready;
    logic [12:0]    line_total;
    logic [10:0]    sprite_total;
    logic [31:0]    hash_now;
    logic [12:0]    line_cfg;
    logic [10:0]    sprite_cfg;
    reveal_result_t expected_results [$];
    reveal_result_t want;
    reveal_result_t got;
    int             fail_tally = 0;

    assign mismatch_count = fail_tally;

    function automatic int unsigned lines_in_use();
        return (line_cfg > LINE_LIMIT) ? LINE_LIMIT : line_cfg;
    endfunction

    function automatic int unsigned sprites_in_use();
        return (sprite_cfg > SPRITE_LIMIT) ? SPRITE_LIMIT : sprite_cfg;
    endfunction

    // FNV-1a over the line bytes followed by the sprite bytes.
    function automatic logic [31:0] fnv_over_store(int unsigned lc, int unsigned sc);
        int unsigned used;
        logic [31:0] h;
        used = ((lc + 7) >> 3) + ((sc + 7) >> 3);
        h = FNV_BASIS;
        for (int unsigned i = 0; i < used && i < STORE_BYTES; i++) begin
            h = (h ^ {24'd0, reveal_bytes[i]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic reveal_result_t predict_request(logic [1:0] kind, logic sel,
                                                       logic [11:0] idx, logic val);
        reveal_result_t res;
        int unsigned lc;
        int unsigned sc;
        int unsigned bound;
        int unsigned slot;
        logic [7:0] mask;
        logic cur;
        lc = lines_in_use();
        sc = sprites_in_use();
        res = '0;
        if (kind == REQ_CLEAR) begin
            foreach (reveal_bytes[i]) reveal_bytes[i] = 8'h00;
            line_total = '0;
            sprite_total = '0;
            if (lc != 0 && sc != 0) begin
                store_ready = 1'b1;
                hash_now = fnv_over_store(lc, sc);
                res.ok = 1'b1;
            end
            else begin
                store_ready = 1'b0;
                hash_now = '0;
            end
        end
        else if ((kind == REQ_READ || kind == REQ_WRITE) && store_ready) begin
            bound = sel ? sc : lc;
            if (idx < bound) begin
                // Sprite bits start right after the last line byte.
                slot = (sel ? ((lc + 7) >> 3) : 0) + (idx >> 3);
                mask = 8'h01 << idx[2:0];
                if (slot < STORE_BYTES) begin
                    cur = (reveal_bytes[slot] & mask) != 8'h00;
                    res.ok = 1'b1;
                    if (kind == REQ_READ) begin
                        res.bit_rd = cur;
                    end
                    else if (cur != val) begin
                        reveal_bytes[slot] = val ? (reveal_bytes[slot] | mask)
                                                 : (reveal_bytes[slot] & ~mask);
                        if (sel)
                            sprite_total = val ? sprite_total + 11'd1 : sprite_total - 11'd1;
                        else
                            line_total = val ? line_total + 13'd1 : line_total - 13'd1;
                        hash_now = fnv_over_store(lc, sc);
                    end
                end
            end
        end
        res.lines = line_total;
        res.sprites = sprite_total;
        res.hash = hash_now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (reveal_bytes[i]) reveal_bytes[i] = 8'h00;
            store_ready = 1'b0;
            line_total = '0;
            sprite_total = '0;
            hash_now = '0;
            line_cfg = 13'd1;
            sprite_cfg = 11'd1;
            expected_results.delete();
            pending_count <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_LINE_COUNT)
                    line_cfg = cfg_data;
                else
                    sprite_cfg = cfg_data[10:0];
            end
            if (done) begin
                got = {ok, revealed_out, lines_revealed, sprites_revealed, state_hash};
                if (expected_results.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("[%0t] result transaction with no request pending: ok=%0d",
                                 $time, ok);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display({"[%0t] mismatch: expected ok=%0d rd=%0d lines=%0d ",
                                      "sprites=%0d hash=%08h, got ok=%0d rd=%0d lines=%0d ",
                                      "sprites=%0d hash=%08h"},
                                     $time, want.ok, want.bit_rd, want.lines, want.sprites,
                                     want.hash, got.ok, got.bit_rd, got.lines, got.sprites,
                                     got.hash);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(
                    predict_request(req_type, which_set, item_index, reveal_value));
            pending_count <= expected_results.size();
        end
    end

endmodule

>>> tb/tb_hashed_reveal_bitmap_store_unit.sv
`timescale 1ns / 1ps
// Testbench top for the hashed reveal bitmap store: clock, reset, stimulus and verdict.
module tb_hashed_reveal_bitmap_store_unit
    import hrbs_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic SET_LINE   = 1'b0;
    localparam logic SET_SPRITE = 1'b1;
    localparam int LINE_LIMIT     = 4096;
    localparam int SPRITE_LIMIT   = 1024;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int PHASES         = 12;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic        which_set;
    logic [11:0] item_index;
    logic        reveal_value;
    logic        done;
    logic        ok;
    logic        revealed_out;
    logic [12:0] lines_revealed;
    logic [10:0] sprites_revealed;
    logic [31:0] state_hash;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;

    int mismatch_count;
    int pending_count;
    int idle_cycles = 0;
    int burst_left;
    int cur_lines;
    int cur_sprites;

    hashed_reveal_bitmap_store_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .which_set        (which_set),
        .item_index       (item_index),
        .reveal_value     (reveal_value),
        .done             (done),
        .ok               (ok),
        .revealed_out     (revealed_out),
        .lines_revealed   (lines_revealed),
        .sprites_revealed (sprites_revealed),
        .state_hash       (state_hash),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    hrbs_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .which_set        (which_set),
        .item_index       (item_index),
        .reveal_value     (reveal_value),
        .done             (done),
        .ok               (ok),
        .revealed_out     (revealed_out),
        .lines_revealed   (lines_revealed),
        .sprites_revealed (sprites_revealed),
        .state_hash       (state_hash),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    always #10 clk = ~clk;

    // Any accepted transaction or register write resets the stall counter.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int eff_count(int cfg, int limit);
        return (cfg > limit) ? limit : cfg;
    endfunction

    task automatic send_req(logic [1:0] kind, logic sel, logic [11:0] idx, logic val);
        int gap;
        start <= 1'b1;
        req_type <= kind;
        which_set <= sel;
        item_index <= idx;
        reveal_value <= val;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        if (start) start <= 1'b0;
        do @(posedge clk); while (pending_count != 0 || busy);
    endtask

    task automatic write_cfg(bit do_line, logic [12:0] line_val,
                             bit do_sprite, logic [12:0] sprite_val);
        wait_idle();
        if (do_line)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_LINE_COUNT;
            cfg_data <= line_val;
            @(posedge clk);
            cur_lines = int'(line_val);
        end
        if (do_sprite)
        begin
            if (!do_line) cfg_we <= 1'b1;
            cfg_index <= CFG_SPRITE_COUNT;
            cfg_data <= sprite_val;
            @(posedge clk);
            cur_sprites = int'(sprite_val[10:0]);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly in-range reads and writes, with clears, rejected indexes and noise mixed in.
    task automatic random_item();
        int pick;
        int lim;
        logic sel;
        logic [11:0] idx;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        sel = 1'($urandom_range(0, 1));
        lim = sel ? eff_count(cur_sprites, SPRITE_LIMIT) : eff_count(cur_lines, LINE_LIMIT);
        idx = (lim > 0) ? 12'($urandom_range(lim - 1, 0)) : 12'($urandom_range(4095, 0));
        kind = (pick < 45) ? REQ_WRITE : REQ_READ;
        if (pick >= 75 && pick < 80)
        begin
            kind = REQ_CLEAR;
        end
        else if (pick >= 80 && pick < 90)
        begin
            kind = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
            if (lim < 4096) idx = 12'($urandom_range(4095, lim));
        end
        else if (pick >= 90 && pick < 95)
        begin
            kind = REQ_UNUSED;
            idx = 12'($urandom);
        end
        else if (pick >= 95)
        begin
            kind = 2'($urandom_range(0, 3));
            idx = 12'($urandom);
        end
        send_req(kind, sel, idx, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        start = 1'b0;
        req_type = REQ_CLEAR;
        which_set = SET_LINE;
        item_index = '0;
        reveal_value = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LINE_COUNT;
        cfg_data = '0;
        rst_n = 1'b0;
        burst_left = 0;
        cur_lines = 1;
        cur_sprites = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Requests before the first clear must be refused.
        send_req(REQ_READ, SET_LINE, 12'd0, 1'b0);
        send_req(REQ_WRITE, SET_SPRITE, 12'd0, 1'b1);
        send_req(REQ_UNUSED, SET_SPRITE, 12'hFFF, 1'b1);
        send_req(REQ_CLEAR, SET_LINE, 12'd0, 1'b0);
        send_req(REQ_WRITE, SET_LINE, 12'd0, 1'b1);
        send_req(REQ_WRITE, SET_SPRITE, 12'd0, 1'b1);
        send_req(REQ_READ, SET_SPRITE, 12'd0, 1'b0);
        send_req(REQ_WRITE, SET_LINE, 12'd1, 1'b1);

        // A clear with a zero line count leaves the block not ready.
        write_cfg(1'b1, 13'd0, 1'b0, 13'd0);
        send_req(REQ_CLEAR, SET_LINE, 12'd0, 1'b0);
        send_req(REQ_READ, SET_SPRITE, 12'd0, 1'b0);

        write_cfg(1'b1, 13'd4096, 1'b1, 13'd1024);
        send_req(REQ_CLEAR, SET_SPRITE, 12'hFFF, 1'b1);
        send_req(REQ_WRITE, SET_LINE, 12'd4095, 1'b1);
        send_req(REQ_WRITE, SET_SPRITE, 12'd1023, 1'b1);
        send_req(REQ_READ, SET_LINE, 12'd4095, 1'b0);
        send_req(REQ_READ, SET_SPRITE, 12'd1023, 1'b0);
        send_req(REQ_WRITE, SET_SPRITE, 12'd1023, 1'b1);
        send_req(REQ_WRITE, SET_SPRITE, 12'hFFF, 1'b1);
        send_req(REQ_WRITE, SET_LINE, 12'd4095, 1'b0);
        send_req(REQ_READ, SET_LINE, 12'd2048, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_cfg(1'b1, 13'd4096, 1'b1, 13'd1024);
                1: write_cfg(1'b1, 13'd1, 1'b1, 13'd1);
                2: write_cfg(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
                3: write_cfg(1'b1, 13'd0, 1'b1, 13'($urandom_range(1, 16)));
                4: write_cfg(1'b1, 13'($urandom_range(1, 64)), 1'b1, 13'd0);
                5: write_cfg(1'b1, 13'($urandom_range(1, 4096)),
                             1'b1, 13'($urandom_range(1, 1024)));
                default: write_cfg($urandom_range(0, 3) != 0, 13'($urandom_range(1, 64)),
                                   $urandom_range(0, 3) != 0, 13'($urandom_range(1, 32)));
            endcase
            // Later phases sometimes keep the old store under the new layout.
            if (p < 6 || $urandom_range(0, 3) != 0)
                send_req(REQ_CLEAR, 1'($urandom_range(0, 1)), 12'($urandom),
                         1'($urandom_range(0, 1)));
            repeat ((p == 3 || p == 4) ? 20 : 90) random_item();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
